### sv/cvz_pkg.sv
// Shared types, constants and register codes of the 3x3 convolution block.
`default_nettype none
package cvz_pkg;

	localparam int MAX_LINE_DEF   = 1024;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int COEF_W         = 5;
	localparam int TAPS           = 9;
	localparam int LINE_W         = 17;
	localparam int MASK_W         = 45;
	localparam int DIV_W          = 8;
	localparam int LEVEL_W        = 16;
	localparam int LLEN_W         = 11;
	localparam int LCNT_W         = 16;
	localparam int APB_AW         = 6;
	localparam int APB_DW         = 64;

	localparam logic [MASK_W-1:0]  MASK_RST   = 45'd1048576;
	localparam logic [DIV_W-1:0]   DIV_RST    = 8'd1;
	localparam logic [LEVEL_W-1:0] OFFSET_RST = 16'd0;
	localparam logic [LEVEL_W-1:0] MAX_RST    = 16'd255;
	localparam logic [LLEN_W-1:0]  LLEN_RST   = 11'd1024;
	localparam logic [LCNT_W-1:0]  LCNT_RST   = 16'd1;

	typedef enum logic [2:0] {
		REG_MASK    = 3'd0,
		REG_DIVISOR = 3'd1,
		REG_OFFSET  = 3'd2,
		REG_MAX     = 3'd3,
		REG_LLEN    = 3'd4,
		REG_LCNT    = 3'd5
	} cvz_reg_t;

	// per-item control handed from the input counters to the line buffer
	typedef struct packed {
		logic act;     // item touches line stores and window
		logic clr;     // window cleared before this item
		logic up_en;   // upper line exists
		logic mid_en;  // middle line exists
		logic q0;      // first position of a line
		logic emit;    // item produces a result
		logic last;    // result closes the image
	} cvz_ctl_t;

endpackage
`default_nettype wire

### sv/cvz_linebuf.sv
// Two line stores with read-modify-write, forwarding and the 3x3 window.
`default_nettype none
module cvz_linebuf #(
	parameter int MAX_LINE   = cvz_pkg::MAX_LINE_DEF,
	parameter int PIXEL_BITS = cvz_pkg::PIXEL_BITS_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     en,
	input  wire                                     in_valid,
	input  cvz_pkg::cvz_ctl_t                       ctl,
	input  wire  [$clog2(MAX_LINE)-1:0]             addr,
	input  wire  [PIXEL_BITS-1:0]                   cur,
	output logic                                    win_valid,
	output logic                                    win_last,
	output logic [cvz_pkg::TAPS*PIXEL_BITS-1:0]     win
);
	localparam int AW = $clog2(MAX_LINE);
	localparam int PB = PIXEL_BITS;

	logic [PB-1:0] upper_mem [0:MAX_LINE-1];
	logic [PB-1:0] middle_mem [0:MAX_LINE-1];
	logic [PB-1:0] rd_up_q, rd_mid_q;

	logic              v_s1;
	cvz_pkg::cvz_ctl_t ctl_s1;
	logic [AW-1:0]     q_s1;
	logic [PB-1:0]     cur_s1;
	logic              fwd_s1;
	logic [PB-1:0]     fwd_up_s1, fwd_mid_s1;

	logic [PB-1:0] win_q [0:cvz_pkg::TAPS-1];
	logic [PB-1:0] base [0:cvz_pkg::TAPS-1];
	logic [PB-1:0] nw [0:cvz_pkg::TAPS-1];
	logic [PB-1:0] fw [0:cvz_pkg::TAPS-1];
	logic [PB-1:0] col [0:2];
	logic [PB-1:0] up, mid;
	logic          wr_en;

	assign wr_en = v_s1 && en && ctl_s1.act;

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			rd_up_q  <= upper_mem[addr];
			rd_mid_q <= middle_mem[addr];
		end
		if (wr_en) begin
			upper_mem[q_s1]  <= mid;
			middle_mem[q_s1] <= cur_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	// a write at the same edge as the read of the same entry is forwarded
	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			ctl_s1     <= ctl;
			q_s1       <= addr;
			cur_s1     <= cur;
			fwd_s1     <= wr_en && (q_s1 == addr);
			fwd_up_s1  <= mid;
			fwd_mid_s1 <= cur_s1;
		end
	end

	always_comb begin
		up  = fwd_s1 ? fwd_up_s1 : rd_up_q;
		mid = fwd_s1 ? fwd_mid_s1 : rd_mid_q;
		if (!ctl_s1.up_en)
			up = '0;
		if (!ctl_s1.mid_en)
			mid = '0;
		col[0] = up;
		col[1] = mid;
		col[2] = cur_s1;
		for (int k = 0; k < cvz_pkg::TAPS; k++)
			base[k] = ctl_s1.clr ? '0 : win_q[k];
		for (int r = 0; r < 3; r++) begin
			if (ctl_s1.q0) begin
				// close the previous line with a zero column on the right
				fw[r*3]     = base[r*3+1];
				fw[r*3+1]   = base[r*3+2];
				fw[r*3+2]   = '0;
				nw[r*3]     = '0;
				nw[r*3+1]   = '0;
				nw[r*3+2]   = col[r];
			end else begin
				nw[r*3]     = base[r*3+1];
				nw[r*3+1]   = base[r*3+2];
				nw[r*3+2]   = col[r];
				fw[r*3]     = nw[r*3];
				fw[r*3+1]   = nw[r*3+1];
				fw[r*3+2]   = nw[r*3+2];
			end
		end
		if (!ctl_s1.act) begin
			for (int k = 0; k < cvz_pkg::TAPS; k++)
				nw[k] = base[k];
		end
		if (ctl_s1.last) begin
			for (int k = 0; k < cvz_pkg::TAPS; k++)
				nw[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cvz_pkg::TAPS; k++)
				win_q[k] <= '0;
		end else if (v_s1 && en) begin
			for (int k = 0; k < cvz_pkg::TAPS; k++)
				win_q[k] <= nw[k];
		end
	end

	always_comb begin
		for (int k = 0; k < cvz_pkg::TAPS; k++)
			win[k*PB +: PB] = fw[k];
	end

	assign win_valid = v_s1 && ctl_s1.act && ctl_s1.emit;
	assign win_last  = ctl_s1.last;

endmodule
`default_nettype wire

### sv/cvz_mac.sv
// Pipelined weighted sum of the 3x3 window.
`default_nettype none
module cvz_mac #(
	parameter int PIXEL_BITS = cvz_pkg::PIXEL_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_valid,
	input  wire                                 in_last,
	input  wire  [cvz_pkg::TAPS*PIXEL_BITS-1:0] win,
	input  wire  [cvz_pkg::MASK_W-1:0]          mask,
	output logic                                out_valid,
	output logic                                out_last,
	output logic signed [PIXEL_BITS+9:0]        out_sum
);
	localparam int PB  = PIXEL_BITS;
	localparam int PRW = PB + 6;
	localparam int SW  = PB + 10;
	localparam int CW  = cvz_pkg::COEF_W;

	logic [PB-1:0]         win_s2 [0:cvz_pkg::TAPS-1];
	logic signed [PRW-1:0] prod_s3 [0:cvz_pkg::TAPS-1];
	logic signed [SW-1:0]  psum_s4 [0:2];
	logic signed [SW-1:0]  sum_s5;
	logic [3:0]            v_q;
	logic [3:0]            l_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_q <= {l_q[2:0], in_last};
			for (int k = 0; k < cvz_pkg::TAPS; k++)
				win_s2[k] <= win[k*PB +: PB];
			// tap r*3+c takes coefficient c*3+r
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					prod_s3[r*3+c] <= PRW'($signed(mask[CW*(c*3+r) +: CW]))
						* PRW'($signed({1'b0, win_s2[r*3+c]}));
			for (int g = 0; g < 3; g++)
				psum_s4[g] <= SW'(prod_s3[g*3]) + SW'(prod_s3[g*3+1])
					+ SW'(prod_s3[g*3+2]);
			sum_s5 <= psum_s4[0] + psum_s4[1] + psum_s4[2];
		end
	end

	assign out_valid = v_q[3];
	assign out_last  = l_q[3];
	assign out_sum   = sum_s5;

endmodule
`default_nettype wire

### sv/cvz_div.sv
// Pipelined restoring divider, one quotient bit per stage, on the magnitude.
`default_nettype none
module cvz_div #(
	parameter int SW = cvz_pkg::PIXEL_BITS_DEF + 10
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire                       in_valid,
	input  wire                       in_last,
	input  wire signed [SW-1:0]       in_sum,
	input  wire  [cvz_pkg::DIV_W-1:0] divisor,
	output logic                      out_valid,
	output logic                      out_last,
	output logic                      out_neg,
	output logic [SW-1:0]             out_quo,
	output logic                      out_rem_nz
);
	localparam int DW = cvz_pkg::DIV_W;

	logic [SW-1:0] dvd_s [0:SW];
	logic [SW-1:0] quo_s [0:SW];
	logic [DW-1:0] rem_s [0:SW];
	logic          vld_s [0:SW];
	logic          neg_s [0:SW];
	logic          lst_s [0:SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s[0] <= in_sum[SW-1] ? SW'(-in_sum) : SW'(in_sum);
			quo_s[0] <= '0;
			rem_s[0] <= '0;
			neg_s[0] <= in_sum[SW-1];
			lst_s[0] <= in_last;
		end
	end

	for (genvar i = 0; i < SW; i++) begin : g_stage
		logic [DW:0] r2;
		logic        ge;
		assign r2 = {rem_s[i], dvd_s[i][SW-1]};
		assign ge = r2 >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[i+1] <= {dvd_s[i][SW-2:0], 1'b0};
				quo_s[i+1] <= {quo_s[i][SW-2:0], ge};
				rem_s[i+1] <= ge ? DW'(r2 - {1'b0, divisor}) : DW'(r2);
				neg_s[i+1] <= neg_s[i];
				lst_s[i+1] <= lst_s[i];
			end
		end
	end

	assign out_valid  = vld_s[SW];
	assign out_last   = lst_s[SW];
	assign out_neg    = neg_s[SW];
	assign out_quo    = quo_s[SW];
	assign out_rem_nz = rem_s[SW] != '0;

endmodule
`default_nettype wire

### sv/conv3x3_zero_pad_clamp.sv
// Top level: configuration registers, raster counters, post-scaling and output register.
// 3x3 convolution of a raster greyscale stream with zero padding: each pixel's
// neighbourhood is weighted by nine signed 5-bit coefficients, floor-divided by
// the divisor, offset and clamped to 0..max_level. One item is taken per clock
// unless the pipeline is stalled; each of the two line stores is read once and
// written at most once per item through one read port and one write port.
// Results trail the input by one line plus one pixel, so flush items (tuser high)
// drain the tail; results pass through the multiply, sum, divider (one quotient
// bit per stage) and clamp stages. The whole pipeline stalls together when the
// output register is full and not taken. No clearing pass after reset.
`default_nettype none
module conv3x3_zero_pad_clamp #(
	parameter int MAX_LINE   = cvz_pkg::MAX_LINE_DEF,
	parameter int PIXEL_BITS = cvz_pkg::PIXEL_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [15:0]                  s_tdata,  // pixel
	input  wire                          s_tuser,  // kind
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [15:0]                  m_tdata,  // result_pixel
	output logic                         m_tlast,  // last
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire  [cvz_pkg::APB_AW-1:0]   paddr,
	input  wire  [cvz_pkg::APB_DW-1:0]   pwdata,
	output logic [cvz_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	localparam int PB = PIXEL_BITS;
	localparam int AW = $clog2(MAX_LINE);
	localparam int LW = $clog2(MAX_LINE + 1);
	localparam int CW = LW + cvz_pkg::LCNT_W;
	localparam int SW = PB + 10;
	localparam int LNW = cvz_pkg::LINE_W;

	logic [cvz_pkg::MASK_W-1:0]  mask_q;
	logic [cvz_pkg::DIV_W-1:0]   div_q;
	logic [cvz_pkg::LEVEL_W-1:0] off_q;
	logic [cvz_pkg::LEVEL_W-1:0] max_q;
	logic [cvz_pkg::LLEN_W-1:0]  llen_q;
	logic [cvz_pkg::LCNT_W-1:0]  lcnt_q;
	cvz_pkg::cvz_reg_t           widx;

	assign pready = 1'b1;
	assign widx   = cvz_pkg::cvz_reg_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= cvz_pkg::MASK_RST;
			div_q  <= cvz_pkg::DIV_RST;
			off_q  <= cvz_pkg::OFFSET_RST;
			max_q  <= cvz_pkg::MAX_RST;
			llen_q <= cvz_pkg::LLEN_RST;
			lcnt_q <= cvz_pkg::LCNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (widx)
				cvz_pkg::REG_MASK:    mask_q <= pwdata[cvz_pkg::MASK_W-1:0];
				cvz_pkg::REG_DIVISOR: div_q  <= pwdata[cvz_pkg::DIV_W-1:0];
				cvz_pkg::REG_OFFSET:  off_q  <= pwdata[cvz_pkg::LEVEL_W-1:0];
				cvz_pkg::REG_MAX:     max_q  <= pwdata[cvz_pkg::LEVEL_W-1:0];
				cvz_pkg::REG_LLEN:    llen_q <= pwdata[cvz_pkg::LLEN_W-1:0];
				cvz_pkg::REG_LCNT:    lcnt_q <= pwdata[cvz_pkg::LCNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (widx)
			cvz_pkg::REG_MASK:    prdata = cvz_pkg::APB_DW'(mask_q);
			cvz_pkg::REG_DIVISOR: prdata = cvz_pkg::APB_DW'(div_q);
			cvz_pkg::REG_OFFSET:  prdata = cvz_pkg::APB_DW'(off_q);
			cvz_pkg::REG_MAX:     prdata = cvz_pkg::APB_DW'(max_q);
			cvz_pkg::REG_LLEN:    prdata = cvz_pkg::APB_DW'(llen_q);
			cvz_pkg::REG_LCNT:    prdata = cvz_pkg::APB_DW'(lcnt_q);
			default:              prdata = '0;
		endcase
	end

	// effective geometry
	logic [LW-1:0]              w_eff;
	logic [cvz_pkg::LCNT_W-1:0] h_eff;
	logic [CW-1:0]              total;
	logic [cvz_pkg::DIV_W-1:0]  div_eff;
	logic [31:0]                ll32;

	always_comb begin
		ll32 = 32'(llen_q);
		if (ll32 == 32'd0)
			w_eff = LW'(1);
		else if (ll32 > 32'(MAX_LINE))
			w_eff = LW'(MAX_LINE);
		else
			w_eff = LW'(ll32);
		h_eff   = (lcnt_q == '0) ? cvz_pkg::LCNT_W'(1) : lcnt_q;
		div_eff = (div_q == '0) ? cvz_pkg::DIV_W'(1) : div_q;
		total   = CW'(w_eff) * CW'(h_eff);
	end

	// input counters
	logic              adv, acc;
	logic [AW-1:0]     pos_q;
	logic [LNW-1:0]    line_q;
	logic [CW-1:0]     emitted_q;
	logic              rst_img;
	logic [LW-1:0]     pos0, pos1, pos2;
	logic [LNW-1:0]    line0, line1, line2;
	logic [CW-1:0]     em0, em1;
	logic              ignore, emit, last;
	logic [PB-1:0]     cur;
	cvz_pkg::cvz_ctl_t ctl;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign acc      = s_tvalid && adv;

	always_comb begin
		rst_img = emitted_q >= total;
		pos0    = rst_img ? '0 : LW'(pos_q);
		line0   = rst_img ? '0 : line_q;
		em0     = rst_img ? '0 : emitted_q;
		if (pos0 >= w_eff) begin
			pos1  = '0;
			line1 = line0 + LNW'(1);
		end else begin
			pos1  = pos0;
			line1 = line0;
		end
		ignore = s_tuser && (line1 == '0) && (pos1 == '0);
		emit   = ((line1 >= LNW'(2)) || ((line1 == LNW'(1)) && (pos1 != '0)))
			&& (em0 < total) && !ignore;
		cur    = (!s_tuser && (line1 < LNW'(h_eff))) ? s_tdata[PB-1:0] : '0;
		em1    = em0 + CW'(emit);
		last   = emit && (em1 >= total);
		pos2   = pos1 + LW'(1);
		line2  = line1;
		if (ignore) begin
			pos2 = pos1;
		end else if (pos2 >= w_eff) begin
			pos2  = '0;
			line2 = line1 + LNW'(1);
		end
		if (last) begin
			pos2  = '0;
			line2 = '0;
			em1   = '0;
		end
		ctl.act    = !ignore;
		ctl.clr    = rst_img;
		ctl.up_en  = line1 >= LNW'(2);
		ctl.mid_en = line1 >= LNW'(1);
		ctl.q0     = pos1 == '0;
		ctl.emit   = emit;
		ctl.last   = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			line_q    <= '0;
			emitted_q <= '0;
		end else if (acc) begin
			pos_q     <= pos2[AW-1:0];
			line_q    <= line2;
			emitted_q <= em1;
		end
	end

	logic                    win_valid, win_last;
	logic [9*PB-1:0]         win;
	logic                    sum_valid, sum_last;
	logic signed [SW-1:0]    sum;
	logic                    dv_valid, dv_last, dv_neg, dv_rnz;
	logic [SW-1:0]           dv_quo;

	cvz_linebuf #(.MAX_LINE(MAX_LINE), .PIXEL_BITS(PIXEL_BITS)) u_linebuf (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(acc), .ctl(ctl),
		.addr(pos1[AW-1:0]), .cur(cur),
		.win_valid(win_valid), .win_last(win_last), .win(win)
	);

	cvz_mac #(.PIXEL_BITS(PIXEL_BITS)) u_mac (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(win_valid),
		.in_last(win_last), .win(win), .mask(mask_q),
		.out_valid(sum_valid), .out_last(sum_last), .out_sum(sum)
	);

	cvz_div #(.SW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(sum_valid),
		.in_last(sum_last), .in_sum(sum), .divisor(div_eff),
		.out_valid(dv_valid), .out_last(dv_last), .out_neg(dv_neg),
		.out_quo(dv_quo), .out_rem_nz(dv_rnz)
	);

	// floor quotient, then offset and clamp
	logic                   qv_s1, ql_s1;
	logic signed [SW:0]     qs_s1;
	logic signed [SW+1:0]   v;
	logic [15:0]            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1    <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (adv) begin
			qv_s1    <= dv_valid;
			m_tvalid <= qv_s1;
		end
	end

	always_comb begin
		v = (SW+2)'(qs_s1) + (SW+2)'($signed(off_q));
		if (v <= 0)
			res = '0;
		else if (v >= $signed((SW+2)'(max_q)))
			res = max_q;
		else
			res = v[15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ql_s1   <= dv_last;
			qs_s1   <= dv_neg ? -$signed((SW+1)'(dv_quo)) - $signed((SW+1)'(dv_rnz))
				: $signed((SW+1)'(dv_quo));
			m_tdata <= res;
			m_tlast <= ql_s1;
		end
	end

endmodule
`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the 3x3 zero-padded convolution with clamp.
`default_nettype none
module testbench;
	import cvz_pkg::*;

	localparam int MAXL        = 1024;
	localparam int DRAIN_WAIT  = 2 * (PIXEL_BITS_DEF + 17) + 10;
	localparam int RAND_ITEMS  = 310;
	localparam int RDY_ALWAYS  = 0;
	localparam int RDY_RANDOM  = 1;
	localparam int RDY_PERIOD  = 2;
	localparam logic KIND_PIX   = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef struct {
		logic [15:0] pix;
		logic        last;
	} result_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tuser;
	logic [15:0] s_tdata;                  // pixel
	logic m_tvalid, m_tready, m_tlast;
	logic [15:0] m_tdata;                  // result_pixel
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	conv3x3_zero_pad_clamp u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the block's registers and state
	logic [MASK_W-1:0] cf_mask;
	logic [7:0]  cf_div;
	logic [15:0] cf_off, cf_max, cf_lcnt;
	logic [10:0] cf_llen;
	int unsigned up_line [MAXL];
	int unsigned mid_line [MAXL];
	int unsigned win [9];
	int unsigned pos, line_no, done_cnt;
	bit image_done;

	result_t pixel_q[$];
	int errors, items_sent, results_seen, images_done;
	int burst_left;
	int rdy_mode, rdy_cyc;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report(string msg);
		$display("ERROR: %s", msg);
		errors++;
	endtask

	function automatic longint coef(int idx);
		longint v;
		v = longint'((cf_mask >> (5 * idx)) & 45'd31);
		return (v >= 16) ? v - 32 : v;
	endfunction

	function automatic logic [15:0] filter_window();
		longint sum, q, d, off, v;
		sum = 0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				sum += coef(c * 3 + r) * longint'(win[r*3+c]);
		d = (cf_div != 0) ? longint'(cf_div) : 1;
		q = sum / d;
		if ((sum % d) != 0 && sum < 0)
			q -= 1;
		off = longint'($signed(cf_off));
		v = q + off;
		if (v <= 0)
			return 16'd0;
		if (v >= longint'(cf_max))
			return cf_max;
		return v[15:0];
	endfunction

	task automatic restart_image();
		for (int i = 0; i < 9; i++)
			win[i] = 0;
		pos = 0;
		line_no = 0;
		done_cnt = 0;
	endtask

	task automatic predict_item(logic k, logic [15:0] px);
		int unsigned w, h, total, q, cur, up, mid;
		bit emit;
		result_t res;
		w = 32'(cf_llen);
		if (w == 0) w = 1;
		if (w > MAXL) w = MAXL;
		h = (cf_lcnt != 0) ? 32'(cf_lcnt) : 1;
		total = w * h;
		if (done_cnt >= total)
			restart_image();
		if (pos >= w) begin
			pos = 0;
			line_no++;
		end
		if (k && line_no == 0 && pos == 0)
			return;
		q = pos;
		cur = (!k && line_no < h) ? 32'(px) : 0;
		up = (line_no >= 2) ? up_line[q] : 0;
		mid = (line_no >= 1) ? mid_line[q] : 0;
		up_line[q] = mid;
		mid_line[q] = cur;
		emit = (line_no >= 2 || (line_no == 1 && q >= 1)) && done_cnt < total;
		res.pix = 16'd0;
		if (q == 0) begin
			// close the previous line with a zero column on the right
			for (int r = 0; r < 3; r++) begin
				win[r*3] = win[r*3+1];
				win[r*3+1] = win[r*3+2];
				win[r*3+2] = 0;
			end
			if (emit)
				res.pix = filter_window();
			for (int r = 0; r < 3; r++) begin
				win[r*3] = 0;
				win[r*3+1] = 0;
			end
			win[2] = up;
			win[5] = mid;
			win[8] = cur;
		end else begin
			for (int r = 0; r < 3; r++) begin
				win[r*3] = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = up;
			win[5] = mid;
			win[8] = cur;
			if (emit)
				res.pix = filter_window();
		end
		pos = q + 1;
		if (pos >= w) begin
			pos = 0;
			line_no++;
		end
		if (!emit)
			return;
		done_cnt++;
		res.last = (done_cnt >= total);
		pixel_q.insert(pixel_q.size(), res);
		if (res.last) begin
			restart_image();
			image_done = 1;
			images_done++;
		end
	endtask

	task automatic send_item(logic k, logic [15:0] px);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(k, px);
		items_sent++;
		burst_left--;
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic reg_write(cvz_reg_t r, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (r)
			REG_MASK:    cf_mask = v[MASK_W-1:0];
			REG_DIVISOR: cf_div  = v[7:0];
			REG_OFFSET:  cf_off  = v[15:0];
			REG_MAX:     cf_max  = v[15:0];
			REG_LLEN:    cf_llen = v[10:0];
			REG_LCNT:    cf_lcnt = v[15:0];
			default: ;
		endcase
	endtask

	// npix raster positions, then tail items until the last result is predicted
	task automatic feed_image(int npix, int flush_pct, bit lead_flush);
		logic [15:0] px;
		image_done = 0;
		if (lead_flush)
			send_item(KIND_FLUSH, 16'($urandom));
		for (int i = 0; !image_done; i++) begin
			px = 16'($urandom);
			if (i < npix)
				send_item(($urandom_range(1, 100) <= flush_pct) ? KIND_FLUSH : KIND_PIX, px);
			else
				send_item($urandom_range(0, 3) != 0 ? KIND_FLUSH : KIND_PIX, px);
		end
	endtask

	task automatic set_geometry(logic [10:0] ll, logic [15:0] lc);
		reg_write(REG_LLEN, 64'(ll));
		reg_write(REG_LCNT, 64'(lc));
	endtask

	function automatic int geom_pixels();
		int w, h;
		w = (cf_llen == 0) ? 1 : ((cf_llen > MAXL) ? MAXL : int'(cf_llen));
		h = (cf_lcnt == 0) ? 1 : int'(cf_lcnt);
		return w * h;
	endfunction

	task automatic test_reset_values();
		// mask, divisor, offset and clamp at their reset values on a small image
		set_geometry(11'd4, 16'd3);
		feed_image(geom_pixels(), 0, 1);
		go_idle();
	endtask

	task automatic test_extremes();
		logic [MASK_W-1:0] m;
		set_geometry(11'd3, 16'd3);
		m = '0;
		for (int i = 0; i < TAPS; i++)
			m[i*5 +: 5] = 5'b10000;
		reg_write(REG_MASK, 64'(m));
		reg_write(REG_DIVISOR, 64'd255);
		reg_write(REG_OFFSET, 64'hFFFF_FFFF_FFFF_8000);
		reg_write(REG_MAX, 64'd65535);
		feed_image(9, 0, 0);
		go_idle();
		for (int i = 0; i < TAPS; i++)
			m[i*5 +: 5] = 5'b01111;
		reg_write(REG_MASK, 64'(m));
		reg_write(REG_DIVISOR, 64'd0);
		reg_write(REG_OFFSET, 64'd32767);
		feed_image(9, 0, 0);
		go_idle();
		reg_write(REG_MAX, 64'd0);
		feed_image(9, 20, 0);
		go_idle();
		reg_write(REG_MAX, 64'd255);
		reg_write(REG_OFFSET, 64'd0);
		reg_write(REG_DIVISOR, 64'd1);
	endtask

	task automatic test_odd_geometry();
		// zero length acts as one, zero count as one
		set_geometry(11'd0, 16'd5);
		feed_image(5, 20, 1);
		go_idle();
		set_geometry(11'd1, 16'd0);
		feed_image(1, 0, 0);
		go_idle();
	endtask

	task automatic test_shrink_mid_image();
		set_geometry(11'd8, 16'd3);
		image_done = 0;
		repeat (5) send_item(KIND_PIX, 16'($urandom));
		go_idle();
		// position now beyond the new length: the next item starts line one
		reg_write(REG_LLEN, 64'd4);
		feed_image(8, 0, 0);
		go_idle();
	endtask

	task automatic test_random_images();
		int start;
		logic [MASK_W-1:0] m;
		start = items_sent;
		while (items_sent - start < RAND_ITEMS) begin
			m = MASK_W'({$urandom, $urandom});
			reg_write(REG_MASK, 64'(m));
			reg_write(REG_DIVISOR, 64'($urandom_range(0, 3) == 0 ? $urandom_range(1, 4)
				: $urandom_range(0, 255)));
			reg_write(REG_OFFSET, 64'($urandom_range(0, 1) ? $urandom_range(0, 65535)
				: $urandom_range(0, 600)));
			reg_write(REG_MAX, 64'($urandom_range(0, 1) ? $urandom_range(0, 65535)
				: $urandom_range(0, 300)));
			set_geometry(11'($urandom_range(1, 9)), 16'($urandom_range(1, 6)));
			feed_image(geom_pixels(), $urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 4) == 0);
			go_idle();
		end
	endtask

	always @(posedge clk) begin
		rdy_cyc++;
		if (rdy_cyc % 97 == 0)
			rdy_mode = $urandom_range(RDY_ALWAYS, RDY_PERIOD);
		case (rdy_mode)
			RDY_ALWAYS: m_tready <= 1'b1;
			RDY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
			default:    m_tready <= (rdy_cyc % 7) < 4;
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pixel_q.size() == 0) begin
				report($sformatf("unexpected result %0d", m_tdata));
			end else begin
				want = pixel_q.pop_front();
				if (m_tdata !== want.pix)
					report($sformatf("result %0d pixel got %0d want %0d", results_seen,
						m_tdata, want.pix));
				if (m_tlast !== want.last)
					report($sformatf("result %0d tlast got %b want %b", results_seen,
						m_tlast, want.last));
			end
		end
	end

	initial begin
		errors = 0;
		items_sent = 0;
		results_seen = 0;
		images_done = 0;
		burst_left = 0;
		rdy_mode = RDY_ALWAYS;
		rdy_cyc = 0;
		cf_mask = MASK_RST;
		cf_div = DIV_RST;
		cf_off = OFFSET_RST;
		cf_max = MAX_RST;
		cf_llen = LLEN_RST;
		cf_lcnt = LCNT_RST;
		for (int i = 0; i < MAXL; i++) begin
			up_line[i] = 0;
			mid_line[i] = 0;
		end
		restart_image();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= 16'd0;
		m_tready <= 1'b1;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_extremes();
		test_odd_geometry();
		test_shrink_mid_image();
		test_random_images();
		go_idle();
		$display("Sent %0d items over %0d images, checked %0d result pixels.",
			items_sent, images_done, results_seen);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
